### rtl/json_syntax_tokenizer_top_macros.svh
// Assertion macros shared by the tokenizer checkers.
`ifndef JSON_SYNTAX_TOKENIZER_TOP_MACROS_SVH
`define JSON_SYNTAX_TOKENIZER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define JST_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define JST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/jst_pkg.sv
// Types, codes and keyword tables for the JSON syntax tokenizer.
package jst_pkg;

  localparam int MAX_DEPTH = 32;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
  localparam int ADDR_W    = $clog2(MAX_DEPTH);

  localparam logic [3:0] ROLE_WS        = 4'd0;
  localparam logic [3:0] ROLE_OPEN_OBJ  = 4'd1;
  localparam logic [3:0] ROLE_CLOSE_OBJ = 4'd2;
  localparam logic [3:0] ROLE_OPEN_ARR  = 4'd3;
  localparam logic [3:0] ROLE_CLOSE_ARR = 4'd4;
  localparam logic [3:0] ROLE_COLON     = 4'd5;
  localparam logic [3:0] ROLE_COMMA     = 4'd6;
  localparam logic [3:0] ROLE_QUOTE     = 4'd7;
  localparam logic [3:0] ROLE_STRING    = 4'd8;
  localparam logic [3:0] ROLE_NUMBER    = 4'd9;
  localparam logic [3:0] ROLE_KEYWORD   = 4'd10;
  localparam logic [3:0] ROLE_IGNORED   = 4'd11;

  localparam logic [2:0] FC_UNEXPECTED   = 3'd0;
  localparam logic [2:0] FC_KEY          = 3'd1;
  localparam logic [2:0] FC_COLON        = 3'd2;
  localparam logic [2:0] FC_COMMA_BRACE  = 3'd3;
  localparam logic [2:0] FC_COMMA_BRACK  = 3'd4;
  localparam logic [2:0] FC_UNTERMINATED = 3'd5;
  localparam logic [2:0] FC_KEYWORD      = 3'd6;
  localparam logic [2:0] FC_TOO_DEEP     = 3'd7;

  localparam logic [1:0] ST_BUSY     = 2'd0;
  localparam logic [1:0] ST_ACCEPTED = 2'd1;
  localparam logic [1:0] ST_FAILED   = 2'd2;

  localparam logic [5:0] DEPTH_LIMIT_RESET = 6'd32;

  typedef enum logic [12:0] {
    PH_TOP       = 13'h0001,
    PH_VALUE     = 13'h0002,
    PH_ARR_FIRST = 13'h0004,
    PH_OBJ_FIRST = 13'h0008,
    PH_KEY       = 13'h0010,
    PH_COLON     = 13'h0020,
    PH_AFTER     = 13'h0040,
    PH_STRING    = 13'h0080,
    PH_ESCAPE    = 13'h0100,
    PH_NUMBER    = 13'h0200,
    PH_KEYWORD   = 13'h0400,
    PH_DONE      = 13'h0800,
    PH_FAILED    = 13'h1000
  } phase_t;

  typedef struct packed {
    logic [31:0] fault_position;
    logic [2:0]  fault_code;
    logic [1:0]  parse_status;
    logic [5:0]  nesting_depth;
    logic        in_key;
    logic [3:0]  byte_role;
  } res_t;

  // kind 0 true, 1 false, 2 null
  function automatic logic [7:0] kw_char(input logic [1:0] kind, input logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    case (kind)
      2'd1: begin
        case (idx)
          3'd0: ch = "f";
          3'd1: ch = "a";
          3'd2: ch = "l";
          3'd3: ch = "s";
          3'd4: ch = "e";
          default: ch = 8'h00;
        endcase
      end
      2'd2: begin
        case (idx)
          3'd0: ch = "n";
          3'd1: ch = "u";
          3'd2: ch = "l";
          3'd3: ch = "l";
          default: ch = 8'h00;
        endcase
      end
      default: begin
        case (idx)
          3'd0: ch = "t";
          3'd1: ch = "r";
          3'd2: ch = "u";
          3'd3: ch = "e";
          default: ch = 8'h00;
        endcase
      end
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] kind);
    return (kind == 2'd1) ? 3'd5 : 3'd4;
  endfunction

endpackage

### rtl/json_syntax_tokenizer_top.sv
// JSON syntax tokenizer: tags each document byte and tracks container nesting.
// One request per clock while the output buffer has room: every byte or end
// request yields exactly one result, registered when it is taken. The container
// stack lives in a 32 x 1 synchronous-read memory; the innermost kind sits in a
// register and the entry below it is read ahead every cycle, so a close followed
// at once by another close sees the right kind. A two-entry output buffer lets
// input keep flowing for one result while the output side stalls. No clearing
// pass after reset. depth_limit may be written only while idle.
module json_syntax_tokenizer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data,   // depth_limit
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,       // data_byte
  input  logic        s_tuser,       // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata        // byte_role, in_key, nesting_depth, parse_status,
                                     // fault_code, fault_position
);

  localparam int DW = jst_pkg::DEPTH_W;
  localparam int AW = jst_pkg::ADDR_W;

  logic [5:0]             depth_limit;
  jst_pkg::phase_t        phase, phase_next;
  logic [1:0]             num_phase, num_phase_next;
  logic [1:0]             kw_kind, kw_kind_next;
  logic [2:0]             kw_idx, kw_idx_next;
  logic                   str_key, str_key_next;
  logic [DW-1:0]          count, count_next;
  logic                   top_arr, top_arr_next;
  logic                   below_top;
  logic [31:0]            offset;
  logic [31:0]            kw_start, kw_start_next;
  logic [2:0]             fault_code, fault_code_next;
  logic [31:0]            fault_pos, fault_pos_next;

  logic                   stack_mem [jst_pkg::MAX_DEPTH];
  logic [AW-1:0]          rd_addr;
  logic [DW-1:0]          count_eff;

  logic [7:0]             c;
  logic                   is_end, ws, dig, is_e;
  logic                   in_fire, out_fire;
  logic [3:0]             role;
  logic                   do_start, do_key, close_ok, do_after, do_pop, do_push, push_arr;
  logic                   do_fail;
  logic [2:0]             fail_code;
  logic [31:0]            fail_pos;
  logic                   takes;
  logic [31:0]            lim;
  logic [2:0]             ki;
  logic [2:0]             ki_inc;
  jst_pkg::res_t          res;

  jst_pkg::res_t          out_data, skid_data;
  logic                   out_valid, skid_valid;

  assign c       = s_tdata;
  assign is_end  = s_tuser || (c == 8'h00);
  assign ws      = c inside {8'h20, [8'h09:8'h0D]};
  assign dig     = c inside {["0":"9"]};
  assign is_e    = c inside {"e", "E"};
  assign s_tready = !skid_valid;
  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;
  assign lim = (32'(depth_limit) > 32'(jst_pkg::MAX_DEPTH)) ? 32'(jst_pkg::MAX_DEPTH)
                                                            : 32'(depth_limit);
  assign ki     = (kw_idx > 3'd4) ? 3'd4 : kw_idx;
  assign ki_inc = ki + 3'd1;

  always_comb begin
    phase_next      = phase;
    num_phase_next  = num_phase;
    kw_kind_next    = kw_kind;
    kw_idx_next     = kw_idx;
    str_key_next    = str_key;
    count_next      = count;
    top_arr_next    = top_arr;
    kw_start_next   = kw_start;
    fault_code_next = fault_code;
    fault_pos_next  = fault_pos;
    role      = jst_pkg::ROLE_IGNORED;
    do_start  = 1'b0;
    do_key    = 1'b0;
    close_ok  = 1'b0;
    do_after  = 1'b0;
    do_pop    = 1'b0;
    do_push   = 1'b0;
    push_arr  = 1'b0;
    do_fail   = 1'b0;
    fail_code = jst_pkg::FC_UNEXPECTED;
    fail_pos  = offset;
    takes     = 1'b0;

    case (phase)
      jst_pkg::PH_TOP, jst_pkg::PH_VALUE: begin
        do_start = 1'b1;
      end
      jst_pkg::PH_ARR_FIRST: begin
        if (!is_end && c == "]") begin
          do_pop = 1'b1;
          role   = jst_pkg::ROLE_CLOSE_ARR;
        end else begin
          do_start = 1'b1;
        end
      end
      jst_pkg::PH_OBJ_FIRST: begin
        do_key   = 1'b1;
        close_ok = 1'b1;
      end
      jst_pkg::PH_KEY: begin
        do_key = 1'b1;
      end
      jst_pkg::PH_COLON: begin
        if (is_end) begin
          do_fail = 1'b1; fail_code = jst_pkg::FC_COLON;
        end else if (ws) begin
          role = jst_pkg::ROLE_WS;
        end else if (c == ":") begin
          phase_next = jst_pkg::PH_VALUE;
          role = jst_pkg::ROLE_COLON;
        end else begin
          do_fail = 1'b1; fail_code = jst_pkg::FC_COLON;
        end
      end
      jst_pkg::PH_AFTER: begin
        do_after = 1'b1;
      end
      jst_pkg::PH_STRING: begin
        if (is_end) begin
          do_fail = 1'b1; fail_code = jst_pkg::FC_UNTERMINATED;
        end else if (c == "\"") begin
          role = jst_pkg::ROLE_QUOTE;
          if (str_key) phase_next = jst_pkg::PH_COLON;
          else phase_next = (count == '0) ? jst_pkg::PH_DONE : jst_pkg::PH_AFTER;
        end else begin
          role = jst_pkg::ROLE_STRING;
          if (c == "\\") phase_next = jst_pkg::PH_ESCAPE;
        end
      end
      jst_pkg::PH_ESCAPE: begin
        if (is_end) begin
          do_fail = 1'b1; fail_code = jst_pkg::FC_UNTERMINATED;
        end else begin
          phase_next = jst_pkg::PH_STRING;
          role = jst_pkg::ROLE_STRING;
        end
      end
      jst_pkg::PH_NUMBER: begin
        case (num_phase)
          2'd0: begin
            if (dig) takes = 1'b1;
            else if (c == ".") begin takes = 1'b1; num_phase_next = 2'd1; end
            else if (is_e) begin takes = 1'b1; num_phase_next = 2'd2; end
          end
          2'd1: begin
            if (dig) takes = 1'b1;
            else if (is_e) begin takes = 1'b1; num_phase_next = 2'd2; end
          end
          2'd2: begin
            if (dig || c == "+" || c == "-") begin takes = 1'b1; num_phase_next = 2'd3; end
          end
          default: takes = dig;
        endcase
        if (is_end || !takes) num_phase_next = num_phase;
        if (!is_end && takes) begin
          role = jst_pkg::ROLE_NUMBER;
        end else if (count == '0) begin
          phase_next = jst_pkg::PH_DONE;
        end else begin
          do_after = 1'b1;
        end
      end
      jst_pkg::PH_KEYWORD: begin
        if (is_end || c != jst_pkg::kw_char(kw_kind, ki)) begin
          do_fail   = 1'b1;
          fail_code = jst_pkg::FC_KEYWORD;
          fail_pos  = kw_start;
        end else begin
          role        = jst_pkg::ROLE_KEYWORD;
          kw_idx_next = ki_inc;
          if (ki_inc >= jst_pkg::kw_len(kw_kind))
            phase_next = (count == '0) ? jst_pkg::PH_DONE : jst_pkg::PH_AFTER;
        end
      end
      default: role = jst_pkg::ROLE_IGNORED;
    endcase

    if (do_start) begin
      if (is_end) begin
        do_fail = 1'b1;
      end else if (ws) begin
        role = jst_pkg::ROLE_WS;
      end else if (c == "{" || c == "[") begin
        if (32'(count) >= lim) begin
          do_fail = 1'b1; fail_code = jst_pkg::FC_TOO_DEEP;
        end else begin
          do_push  = 1'b1;
          push_arr = (c == "[");
        end
      end else if (c == "\"") begin
        str_key_next = 1'b0;
        phase_next   = jst_pkg::PH_STRING;
        role         = jst_pkg::ROLE_QUOTE;
      end else if (c == "-" || dig) begin
        num_phase_next = 2'd0;
        phase_next     = jst_pkg::PH_NUMBER;
        role           = jst_pkg::ROLE_NUMBER;
      end else if (c == "t" || c == "f" || c == "n") begin
        kw_kind_next  = (c == "t") ? 2'd0 : (c == "f") ? 2'd1 : 2'd2;
        kw_idx_next   = 3'd1;
        kw_start_next = offset;
        phase_next    = jst_pkg::PH_KEYWORD;
        role          = jst_pkg::ROLE_KEYWORD;
      end else begin
        do_fail = 1'b1;
      end
    end

    if (do_key) begin
      if (is_end) begin
        do_fail = 1'b1; fail_code = jst_pkg::FC_KEY;
      end else if (ws) begin
        role = jst_pkg::ROLE_WS;
      end else if (close_ok && c == "}") begin
        do_pop = 1'b1;
        role   = jst_pkg::ROLE_CLOSE_OBJ;
      end else if (c == "\"") begin
        str_key_next = 1'b1;
        phase_next   = jst_pkg::PH_STRING;
        role         = jst_pkg::ROLE_QUOTE;
      end else begin
        do_fail = 1'b1; fail_code = jst_pkg::FC_KEY;
      end
    end

    if (do_after) begin
      phase_next = jst_pkg::PH_AFTER;
      if (!is_end && ws) begin
        role = jst_pkg::ROLE_WS;
      end else if (top_arr) begin
        if (!is_end && c == "]") begin
          do_pop = 1'b1; role = jst_pkg::ROLE_CLOSE_ARR;
        end else if (!is_end && c == ",") begin
          phase_next = jst_pkg::PH_VALUE; role = jst_pkg::ROLE_COMMA;
        end else begin
          do_fail = 1'b1; fail_code = jst_pkg::FC_COMMA_BRACK;
        end
      end else begin
        if (!is_end && c == "}") begin
          do_pop = 1'b1; role = jst_pkg::ROLE_CLOSE_OBJ;
        end else if (!is_end && c == ",") begin
          phase_next = jst_pkg::PH_KEY; role = jst_pkg::ROLE_COMMA;
        end else begin
          do_fail = 1'b1; fail_code = jst_pkg::FC_COMMA_BRACE;
        end
      end
    end

    if (do_push) begin
      count_next   = count + DW'(1);
      top_arr_next = push_arr;
      phase_next   = push_arr ? jst_pkg::PH_ARR_FIRST : jst_pkg::PH_OBJ_FIRST;
      role         = push_arr ? jst_pkg::ROLE_OPEN_ARR : jst_pkg::ROLE_OPEN_OBJ;
    end

    if (do_pop) begin
      count_next   = count - DW'(1);
      top_arr_next = below_top;
      phase_next   = (count == DW'(1)) ? jst_pkg::PH_DONE : jst_pkg::PH_AFTER;
    end

    if (do_fail) begin
      phase_next      = jst_pkg::PH_FAILED;
      fault_code_next = fail_code;
      fault_pos_next  = fail_pos;
      role            = jst_pkg::ROLE_IGNORED;
    end
  end

  always_comb begin
    res.byte_role      = role;
    res.in_key         = (role == jst_pkg::ROLE_QUOTE || role == jst_pkg::ROLE_STRING)
                         && str_key_next;
    res.nesting_depth  = 6'(count_next);
    res.parse_status   = (phase_next == jst_pkg::PH_FAILED) ? jst_pkg::ST_FAILED :
                         (phase_next == jst_pkg::PH_DONE)   ? jst_pkg::ST_ACCEPTED :
                                                              jst_pkg::ST_BUSY;
    res.fault_code     = (phase_next == jst_pkg::PH_FAILED) ? fault_code_next : 3'd0;
    res.fault_position = (phase_next == jst_pkg::PH_FAILED) ? fault_pos_next : 32'd0;
  end

  // Read ahead the entry below the new top; a push writes one above it,
  // so read and write never hit the same entry.
  assign count_eff = in_fire ? count_next : count;
  assign rd_addr   = AW'(count_eff - DW'(2));

  always_ff @(posedge clk) begin
    if (in_fire && do_push) stack_mem[count[AW-1:0]] <= push_arr;
    below_top <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_limit <= jst_pkg::DEPTH_LIMIT_RESET;
      phase       <= jst_pkg::PH_TOP;
      num_phase   <= 2'd0;
      kw_kind     <= 2'd0;
      kw_idx      <= 3'd0;
      str_key     <= 1'b0;
      count       <= '0;
      top_arr     <= 1'b0;
      offset      <= 32'd0;
      kw_start    <= 32'd0;
      fault_code  <= 3'd0;
      fault_pos   <= 32'd0;
    end else begin
      if (cfg_wr_en) depth_limit <= cfg_wr_data;
      if (in_fire) begin
        phase      <= phase_next;
        num_phase  <= num_phase_next;
        kw_kind    <= kw_kind_next;
        kw_idx     <= kw_idx_next;
        str_key    <= str_key_next;
        count      <= count_next;
        top_arr    <= top_arr_next;
        kw_start   <= kw_start_next;
        fault_code <= fault_code_next;
        fault_pos  <= fault_pos_next;
        if (!is_end && offset != 32'hFFFF_FFFF) offset <= offset + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      if (!out_valid || out_fire) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      if (skid_valid) skid_valid <= 1'b0;
      else out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (!out_valid || out_fire) out_data <= res;
      else skid_data <= res;
    end else if (out_fire && skid_valid) begin
      out_data <= skid_data;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

### rtl/jst_checker.sv
// Port-level checker for the JSON syntax tokenizer, bound to the top level.
`include "json_syntax_tokenizer_top_macros.svh"

module jst_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  jst_pkg::res_t res;
  logic          stalled;
  logic          not_failed;
  logic          fault_clear;
  logic          accepted;

  assign res         = m_tdata;
  assign stalled     = m_tvalid && !m_tready;
  assign not_failed  = m_tvalid && res.parse_status != jst_pkg::ST_FAILED;
  assign fault_clear = res.fault_code == 3'd0 && res.fault_position == 32'd0;
  assign accepted    = m_tvalid && res.parse_status == jst_pkg::ST_ACCEPTED;

  `JST_ASSERT_NEXT(a_out_hold, stalled, m_tvalid && $stable(m_tdata), "stalled result changed")
  `JST_ASSERT_IMPL(a_no_fault, not_failed, fault_clear, "fault fields set without failure")
  `JST_ASSERT_IMPL(a_accept_depth, accepted, res.nesting_depth == 6'd0, "accepted while nested")
  `JST_ASSERT_IMPL(a_reset_empty, $past(rst), !m_tvalid && s_tready, "busy after reset")

endmodule

bind json_syntax_tokenizer_top jst_checker u_jst_checker (.*);

### dv/testbench.sv
`timescale 1ns / 1ps
// Random JSON streams through the tokenizer, each result checked against a predicted tag.
module testbench;
  import jst_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  localparam logic [1:0] NUM_INT    = 2'd0;
  localparam logic [1:0] NUM_FRAC   = 2'd1;
  localparam logic [1:0] NUM_EXP    = 2'd2;
  localparam logic [1:0] NUM_EXP_DG = 2'd3;

  localparam logic [1:0] KW_TRUE  = 2'd0;
  localparam logic [1:0] KW_FALSE = 2'd1;
  localparam logic [1:0] KW_NULL  = 2'd2;

  class json_tag_tracker;
    logic [5:0]         limit;
    phase_t             ph;
    logic [1:0]         num_ph;
    logic [1:0]         kw_kind;
    logic [2:0]         kw_idx;
    bit                 str_key;
    bit [MAX_DEPTH-1:0] levels;
    int                 depth;
    logic [31:0]        offset;
    logic [31:0]        kw_start;
    bit                 faulted;
    logic [2:0]         f_code;
    logic [31:0]        f_pos;
    res_t               tags_in_flight[$];
    int                 errors;
    string              words[3];

    function new();
      words = '{"true", "false", "null"};
      limit = DEPTH_LIMIT_RESET;
      ph = PH_TOP;
      num_ph = NUM_INT;
      kw_kind = KW_TRUE;
      kw_idx = 3'd0;
      str_key = 1'b0;
      levels = '0;
      depth = 0;
      offset = 32'd0;
      kw_start = 32'd0;
      faulted = 1'b0;
      f_code = FC_UNEXPECTED;
      f_pos = 32'd0;
      errors = 0;
    endfunction

    function bit blank(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function bit numeral(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function logic [7:0] keyword_char(logic [1:0] k, logic [2:0] i);
      if (i >= words[k].len()) return 8'h00;
      return words[k][i];
    endfunction

    function logic [3:0] latch_fault(logic [2:0] code, logic [31:0] pos);
      if (!faulted) begin
        faulted = 1'b1;
        f_code = code;
        f_pos = pos;
      end
      ph = PH_FAILED;
      return ROLE_IGNORED;
    endfunction

    function void finish_value();
      ph = (depth == 0) ? PH_DONE : PH_AFTER;
    endfunction

    function logic [3:0] push_level(bit arr);
      int cap;
      cap = (limit > MAX_DEPTH) ? MAX_DEPTH : int'(limit);
      if (depth >= cap) return latch_fault(FC_TOO_DEEP, offset);
      levels[depth] = arr;
      depth++;
      ph = arr ? PH_ARR_FIRST : PH_OBJ_FIRST;
      return arr ? ROLE_OPEN_ARR : ROLE_OPEN_OBJ;
    endfunction

    function logic [3:0] begin_value(logic [7:0] c, bit fin);
      if (fin) return latch_fault(FC_UNEXPECTED, offset);
      if (blank(c)) return ROLE_WS;
      if (c == "{") return push_level(1'b0);
      if (c == "[") return push_level(1'b1);
      if (c == "\"") begin
        str_key = 1'b0;
        ph = PH_STRING;
        return ROLE_QUOTE;
      end
      if (c == "-" || numeral(c)) begin
        num_ph = NUM_INT;
        ph = PH_NUMBER;
        return ROLE_NUMBER;
      end
      if (c == "t" || c == "f" || c == "n") begin
        kw_kind = (c == "t") ? KW_TRUE : (c == "f") ? KW_FALSE : KW_NULL;
        kw_idx = 3'd1;
        kw_start = offset;
        ph = PH_KEYWORD;
        return ROLE_KEYWORD;
      end
      return latch_fault(FC_UNEXPECTED, offset);
    endfunction

    function logic [3:0] want_key(logic [7:0] c, bit fin, bit close_ok);
      if (fin) return latch_fault(FC_KEY, offset);
      if (blank(c)) return ROLE_WS;
      if (close_ok && c == "}") begin
        depth--;
        finish_value();
        return ROLE_CLOSE_OBJ;
      end
      if (c == "\"") begin
        str_key = 1'b1;
        ph = PH_STRING;
        return ROLE_QUOTE;
      end
      return latch_fault(FC_KEY, offset);
    endfunction

    function logic [3:0] after_item(logic [7:0] c, bit fin);
      bit arr;
      arr = levels[(depth != 0) ? depth - 1 : 0];
      if (!fin && blank(c)) return ROLE_WS;
      if (arr) begin
        if (fin) return latch_fault(FC_COMMA_BRACK, offset);
        if (c == "]") begin
          depth--;
          finish_value();
          return ROLE_CLOSE_ARR;
        end
        if (c == ",") begin
          ph = PH_VALUE;
          return ROLE_COMMA;
        end
        return latch_fault(FC_COMMA_BRACK, offset);
      end
      if (fin) return latch_fault(FC_COMMA_BRACE, offset);
      if (c == "}") begin
        depth--;
        finish_value();
        return ROLE_CLOSE_OBJ;
      end
      if (c == ",") begin
        ph = PH_KEY;
        return ROLE_COMMA;
      end
      return latch_fault(FC_COMMA_BRACE, offset);
    endfunction

    function bit num_accepts(logic [7:0] c);
      case (num_ph)
        NUM_INT: begin
          if (numeral(c)) return 1'b1;
          if (c == ".") begin
            num_ph = NUM_FRAC;
            return 1'b1;
          end
          if (c == "e" || c == "E") begin
            num_ph = NUM_EXP;
            return 1'b1;
          end
          return 1'b0;
        end
        NUM_FRAC: begin
          if (numeral(c)) return 1'b1;
          if (c == "e" || c == "E") begin
            num_ph = NUM_EXP;
            return 1'b1;
          end
          return 1'b0;
        end
        NUM_EXP: begin
          if (c == "+" || c == "-" || numeral(c)) begin
            num_ph = NUM_EXP_DG;
            return 1'b1;
          end
          return 1'b0;
        end
        default: return numeral(c);
      endcase
    endfunction

    function logic [3:0] advance(logic [7:0] c, bit fin);
      case (ph)
        PH_TOP, PH_VALUE: return begin_value(c, fin);
        PH_ARR_FIRST: begin
          if (!fin && c == "]") begin
            depth--;
            finish_value();
            return ROLE_CLOSE_ARR;
          end
          return begin_value(c, fin);
        end
        PH_OBJ_FIRST: return want_key(c, fin, 1'b1);
        PH_KEY: return want_key(c, fin, 1'b0);
        PH_COLON: begin
          if (fin) return latch_fault(FC_COLON, offset);
          if (blank(c)) return ROLE_WS;
          if (c == ":") begin
            ph = PH_VALUE;
            return ROLE_COLON;
          end
          return latch_fault(FC_COLON, offset);
        end
        PH_AFTER: return after_item(c, fin);
        PH_STRING: begin
          if (fin) return latch_fault(FC_UNTERMINATED, offset);
          if (c == "\"") begin
            if (str_key) ph = PH_COLON;
            else finish_value();
            return ROLE_QUOTE;
          end
          if (c == "\\") ph = PH_ESCAPE;
          return ROLE_STRING;
        end
        PH_ESCAPE: begin
          if (fin) return latch_fault(FC_UNTERMINATED, offset);
          ph = PH_STRING;
          return ROLE_STRING;
        end
        PH_NUMBER: begin
          if (!fin && num_accepts(c)) return ROLE_NUMBER;
          finish_value();
          if (ph == PH_AFTER) return after_item(c, fin);
          return ROLE_IGNORED;
        end
        PH_KEYWORD: begin
          if (fin || c != keyword_char(kw_kind, kw_idx)) return latch_fault(FC_KEYWORD, kw_start);
          kw_idx = kw_idx + 3'd1;
          if (kw_idx >= words[kw_kind].len()) finish_value();
          return ROLE_KEYWORD;
        end
        default: return ROLE_IGNORED;
      endcase
    endfunction

    function void tag_byte(bit act, logic [7:0] b);
      res_t tag;
      bit fin;
      bit failed;
      fin = act || b == 8'h00;
      tag.byte_role = advance(b, fin);
      tag.in_key = (tag.byte_role == ROLE_QUOTE || tag.byte_role == ROLE_STRING) && str_key;
      if (!fin && offset != 32'hFFFF_FFFF) offset++;
      failed = (ph == PH_FAILED);
      tag.nesting_depth = 6'(depth);
      tag.parse_status = failed ? ST_FAILED : (ph == PH_DONE) ? ST_ACCEPTED : ST_BUSY;
      tag.fault_code = failed ? f_code : FC_UNEXPECTED;
      tag.fault_position = failed ? f_pos : 32'd0;
      tags_in_flight.push_back(tag);
    endfunction

    task report(string line);
      errors++;
      $display("tb: %s", line);
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s mismatch: got %0d, want %0d", name, got, want));
    endtask

    task match_tag(logic [47:0] raw);
      res_t got;
      res_t want;
      got = raw;
      if (tags_in_flight.size() == 0) begin
        report($sformatf("result %h with no request outstanding", raw));
        return;
      end
      want = tags_in_flight.pop_front();
      check_field("byte_role", 32'(got.byte_role), 32'(want.byte_role));
      check_field("in_key", 32'(got.in_key), 32'(want.in_key));
      check_field("nesting_depth", 32'(got.nesting_depth), 32'(want.nesting_depth));
      check_field("parse_status", 32'(got.parse_status), 32'(want.parse_status));
      check_field("fault_code", 32'(got.fault_code), 32'(want.fault_code));
      check_field("fault_position", got.fault_position, want.fault_position);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [5:0]  cfg_wr_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;

  json_tag_tracker sb = new();
  int cycles = 0;
  int climb = 0;
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;

  json_syntax_tokenizer_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [7:0] blank_byte();
    return ($urandom_range(0, 5) == 5) ? 8'h20 : 8'(8'h09 + $urandom_range(0, 4));
  endfunction

  function automatic logic [7:0] digit_byte();
    return 8'(8'h30 + $urandom_range(0, 9));
  endfunction

  // Next byte of a well-formed document; closing mode winds the document down.
  function automatic logic [7:0] pick_byte(input bit closing);
    int r;
    int cap;
    string lead;
    lead = "tfn";
    r = $urandom_range(0, 99);
    cap = (sb.limit > MAX_DEPTH) ? MAX_DEPTH : int'(sb.limit);
    case (sb.ph)
      PH_TOP, PH_VALUE, PH_ARR_FIRST: begin
        if (!closing && r < 8) return blank_byte();
        if (sb.ph == PH_ARR_FIRST && (closing || r < 20)) return "]";
        if (closing) return digit_byte();
        if (sb.depth < cap && sb.depth < climb && r < 70) return (r < 55) ? "[" : "{";
        case ($urandom_range(0, 2))
          0: return "\"";
          1: return ($urandom_range(0, 3) == 0) ? "-" : digit_byte();
          default: return lead[$urandom_range(0, 2)];
        endcase
      end
      PH_OBJ_FIRST: begin
        if (closing || (r >= 8 && r < 25)) return "}";
        return (r < 8) ? blank_byte() : "\"";
      end
      PH_KEY: return (!closing && r < 10) ? blank_byte() : "\"";
      PH_COLON: return (!closing && r < 10) ? blank_byte() : ":";
      PH_AFTER: begin
        if (!closing && r < 10) return blank_byte();
        if (closing || (sb.depth > 1 && (sb.depth > climb || r < 35)))
          return sb.levels[sb.depth - 1] ? "]" : "}";
        return ",";
      end
      PH_STRING: begin
        if (closing || r < 15) return "\"";
        return 8'($urandom_range(1, 255));
      end
      PH_ESCAPE: return 8'($urandom_range(1, 255));
      PH_NUMBER: begin
        if (closing) return " ";
        if (r < 25) return r[0] ? "," : " ";
        case (sb.num_ph)
          NUM_INT: return (r < 70) ? digit_byte() : (r < 85) ? "." : (r[0] ? "e" : "E");
          NUM_FRAC: return (r < 80) ? digit_byte() : (r[0] ? "e" : "E");
          NUM_EXP: return (r < 60) ? digit_byte() : (r[0] ? "+" : "-");
          default: return digit_byte();
        endcase
      end
      PH_KEYWORD: return sb.keyword_char(sb.kw_kind, sb.kw_idx);
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_req(input bit act, input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= act;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.tag_byte(act, b);
  endtask

  task automatic write_limit(input logic [5:0] v);
    s_tvalid <= 1'b0;
    while (sb.tags_in_flight.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.limit = v;
  endtask

  task automatic reach_value();
    while (!(sb.ph inside {PH_VALUE, PH_ARR_FIRST})) send_req(1'b0, pick_byte(1'b0));
  endtask

  initial begin : result_sink
    int stall;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) recv_burst = !recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.match_tag(m_tdata);
    end
  end

  initial begin : stimulus
    logic [7:0] opening [25];
    logic [5:0] settings [6];
    int         lengths [6];
    int         ending;
    opening = '{8'h09, 8'h20, "[", "\"", 8'hFF, 8'h80, "\\", "\"", "\"", ",",
                "-", "9", ".", "5", "E", "+", "0", ",", "{", "\"", "\"", ":",
                "[", "]", "}"};
    settings = '{6'd63, 6'd0, 6'd1, 6'd2, 6'($urandom_range(3, 31)), 6'd32};
    lengths = '{180, 45, 45, 50, 80, 90};
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 6'd0;
    s_tvalid <= 1'b0;
    s_tdata <= 8'h00;
    s_tuser <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (opening[i]) send_req(1'b0, opening[i]);

    // the top-level array stays open through every depth setting
    for (int p = 0; p < 6; p++) begin
      write_limit(settings[p]);
      climb = (settings[p] > MAX_DEPTH) ? MAX_DEPTH : int'(settings[p]);
      repeat (lengths[p]) begin
        send_req(1'b0, pick_byte(1'b0));
        if (sb.depth >= climb) climb = $urandom_range(1, 8);
      end
    end

    ending = $urandom_range(0, 5);
    case (ending)
      0: begin
        while (sb.ph != PH_DONE) send_req(1'b0, pick_byte(1'b1));
      end
      1: send_req(1'b1, 8'($urandom_range(0, 255)));
      2: send_req(1'b0, 8'h00);
      3: begin
        reach_value();
        write_limit(6'(sb.depth));
        send_req(1'b0, $urandom_range(0, 1) ? "[" : "{");
      end
      4: send_req(1'b0, 8'($urandom_range(0, 255)));
      default: begin
        reach_value();
        send_req(1'b0, "n");
        send_req(1'b0, "u");
        send_req(1'b0, "x");
      end
    endcase
    send_req(1'b1, 8'($urandom_range(0, 255)));
    repeat (12) send_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));

    s_tvalid <= 1'b0;
    while (sb.tags_in_flight.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
